/* rtl/audio_fade_gain_envelope_defines.svh */
// ----------------------------------------------------------------------------
// audio fade gain envelope assertion macros
// shared property wrappers, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef AUDIO_FADE_GAIN_ENVELOPE_DEFINES_SVH
`define AUDIO_FADE_GAIN_ENVELOPE_DEFINES_SVH

// same-cycle implication
`define AFGE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFGE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/afge_pkg.sv */
// ----------------------------------------------------------------------------
// afge_pkg
// widths, register map, queue item and configuration types of the fade block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afge_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CHAN_CFG_W = 7;
  localparam int unsigned RAMP_W     = 17;
  localparam int unsigned UD_W       = 2 * RAMP_W;
  localparam int unsigned MG_W       = SAMPLE_W + GAIN_W;
  localparam int unsigned PART_W     = MG_W + RAMP_W;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned RES_SHIFT  = 44;
  localparam int unsigned RES_W      = PROD_W - RES_SHIFT;

  localparam logic [RAMP_W-1:0] RAMP_ONE  = RAMP_W'(65536);
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (RES_SHIFT - 1);

  localparam int unsigned MAX_CHANNELS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [GAIN_W-1:0]     GAIN_RST  = GAIN_W'(4096);
  localparam logic [POS_W-1:0]      CLIP_RST  = POS_W'(1);
  localparam logic [CHAN_CFG_W-1:0] CHANS_RST = CHAN_CFG_W'(2);

  typedef enum logic [2:0] {
    REG_GAIN     = 3'd0,
    REG_FADE_IN  = 3'd1,
    REG_FADE_OUT = 3'd2,
    REG_CLIP     = 3'd3,
    REG_CHANS    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]     gain;
    logic [POS_W-1:0]      fade_in;
    logic [POS_W-1:0]      fade_out;
    logic [POS_W-1:0]      clip;
    logic [CHAN_CFG_W-1:0] chan_count;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
    logic                outside;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/afge_front.sv */
// ----------------------------------------------------------------------------
// afge_front
// accepts samples, tracks frame position and channel, flags out-of-clip words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afge_front #(
  parameter int unsigned MAX_CHANNELS = afge_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afge_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [afge_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          buf_start_i,
  input  logic [afge_pkg::POS_W-1:0]    first_frame_i,
  input  afge_pkg::queue_status_t       q_status_i,
  output logic                          push_o,
  output afge_pkg::queue_item_t         push_item_o
);
  import afge_pkg::*;

  localparam int unsigned IDX_W = ($clog2(MAX_CHANNELS + 1) > CHAN_CFG_W) ?
                                  $clog2(MAX_CHANNELS + 1) : CHAN_CFG_W;
  localparam logic [IDX_W-1:0] MaxChans = IDX_W'(MAX_CHANNELS);

  logic [IDX_W-1:0] chan_q, chan_d, chan_base, chan_inc, cc_ext, chans_eff;
  logic [POS_W-1:0] pos_q, pos_d, pos_cur;
  logic             accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    cc_ext = IDX_W'(cfg_i.chan_count);
    if (cc_ext == '0) begin
      chans_eff = IDX_W'(1);
    end else if (cc_ext > MaxChans) begin
      chans_eff = MaxChans;
    end else begin
      chans_eff = cc_ext;
    end
    pos_cur   = buf_start_i ? first_frame_i : pos_q;
    chan_base = buf_start_i ? '0 : chan_q;
    chan_inc  = chan_base + IDX_W'(1);
    // a lowered channel count ends the frame after this word
    if (chan_inc >= chans_eff) begin
      chan_d = '0;
      pos_d  = pos_cur + POS_W'(1);
    end else begin
      chan_d = chan_inc;
      pos_d  = pos_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      pos_q  <= '0;
    end else if (accept) begin
      chan_q <= chan_d;
      pos_q  <= pos_d;
    end
  end

  assign push_o              = accept;
  assign push_item_o.sample  = sample_i;
  assign push_item_o.pos     = pos_cur;
  assign push_item_o.outside = (pos_cur >= cfg_i.clip);

endmodule

/* rtl/afge_queue.sv */
// ----------------------------------------------------------------------------
// afge_queue
// short fifo between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afge_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  afge_pkg::queue_item_t   push_item_i,
  input  logic                    pop_i,
  output afge_pkg::queue_item_t   pop_item_o,
  output afge_pkg::queue_status_t status_o
);
  import afge_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] Depth   = CNT_W'(QUEUE_DEPTH);

  queue_item_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == Depth);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_item_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/afge_div.sv */
// ----------------------------------------------------------------------------
// afge_div
// bit-serial ramp divider, one quotient bit a cycle, numerator not above divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afge_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [afge_pkg::POS_W-1:0]  num_i,
  input  logic [afge_pkg::POS_W-1:0]  den_i,
  output logic                        done_o,
  output logic [afge_pkg::RAMP_W-1:0] quot_o
);
  import afge_pkg::*;

  localparam int unsigned CNT_W = $clog2(RAMP_W + 1);

  logic [POS_W:0]       rem_q, trial;
  logic [POS_W-1:0]     den_q;
  logic [RAMP_W-1:0]    quot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, first_q, done_q;
  logic                 ge;

  // first step takes the integer bit, the rest shift in fraction bits
  assign trial  = first_q ? rem_q : {rem_q[POS_W-1:0], 1'b0};
  assign ge     = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
      quot_q <= {quot_q[RAMP_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CNT_W'(RAMP_W);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/afge_back.sv */
// ----------------------------------------------------------------------------
// afge_back
// per-word sequencer: ramp divisions, gain products, rounding and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afge_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afge_pkg::cfg_t                cfg_i,
  input  afge_pkg::queue_status_t       q_status_i,
  input  afge_pkg::queue_item_t         q_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [afge_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                          out_sat_o,
  output logic                          out_outside_o
);
  import afge_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_UP_SET   = 10'b00_0000_0010,
    ST_UP_WAIT  = 10'b00_0000_0100,
    ST_DN_SET   = 10'b00_0000_1000,
    ST_DN_WAIT  = 10'b00_0001_0000,
    ST_MUL_RAMP = 10'b00_0010_0000,
    ST_MUL_LO   = 10'b00_0100_0000,
    ST_MUL_HI   = 10'b00_1000_0000,
    ST_SUM      = 10'b01_0000_0000,
    ST_FINISH   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic                neg_q, outside_q;
  logic [SAMPLE_W-1:0] mag_q;
  logic [POS_W-1:0]    pos_q, start_q, gm1_q;
  logic [RAMP_W-1:0]   up_q, dn_q;
  logic [UD_W-1:0]     ud_q;
  logic [MG_W-1:0]     mg_q;
  logic [PART_W-1:0]   plo_q, phi_q;
  logic [PROD_W-1:0]   prod_q, rnd;
  logic [RES_W-1:0]    res;

  logic                out_valid_q, out_sat_q, out_outside_q;
  logic [SAMPLE_W-1:0] out_sample_q, fin_sample;
  logic                fin_sat, load_out;

  logic                div_start, div_done;
  logic [POS_W-1:0]    div_num, div_den, into;
  logic [RAMP_W-1:0]   div_quot;
  logic                up_const, dn_const;
  logic [RAMP_W-1:0]   up_val, dn_val;

  afge_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ramp special cases and divider operands
  always_comb begin
    up_const = 1'b1;
    up_val   = RAMP_ONE;
    if (cfg_i.fade_in == '0 || pos_q >= cfg_i.fade_in) begin
      up_val = RAMP_ONE;
    end else if (cfg_i.fade_in == POS_W'(1)) begin
      up_val = '0;
    end else begin
      up_const = 1'b0;
    end

    into     = pos_q - start_q;
    dn_const = 1'b1;
    dn_val   = RAMP_ONE;
    if (cfg_i.fade_out == '0 || pos_q < start_q) begin
      dn_val = RAMP_ONE;
    end else if (cfg_i.fade_out == POS_W'(1) || into > gm1_q) begin
      dn_val = '0;
    end else begin
      dn_const = 1'b0;
    end

    if (state_q == ST_UP_SET) begin
      div_num   = pos_q;
      div_den   = cfg_i.fade_in - POS_W'(1);
      div_start = !up_const;
    end else begin
      div_num   = gm1_q - into;
      div_den   = gm1_q;
      div_start = (state_q == ST_DN_SET) && !dn_const;
    end
  end

  // rounding, saturation and outside-clip zeroing
  always_comb begin
    rnd        = prod_q + ROUND_ADD;
    res        = rnd[PROD_W-1:RES_SHIFT];
    fin_sat    = 1'b0;
    fin_sample = '0;
    if (outside_q) begin
      fin_sample = '0;
    end else if (neg_q) begin
      if (res > RES_W'(32768)) begin
        fin_sat    = 1'b1;
        fin_sample = SAMPLE_W'(16'h8000);
      end else begin
        fin_sample = SAMPLE_W'(RES_W'(0) - res);
      end
    end else begin
      if (res > RES_W'(32767)) begin
        fin_sat    = 1'b1;
        fin_sample = SAMPLE_W'(16'h7fff);
      end else begin
        fin_sample = res[SAMPLE_W-1:0];
      end
    end
  end

  assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign pop_o    = (state_q == ST_IDLE) && !q_status_i.empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = q_item_i.outside ? ST_FINISH : ST_UP_SET;
        end
      end
      ST_UP_SET:   state_d = up_const ? ST_DN_SET : ST_UP_WAIT;
      ST_UP_WAIT:  state_d = div_done ? ST_DN_SET : ST_UP_WAIT;
      ST_DN_SET:   state_d = dn_const ? ST_MUL_RAMP : ST_DN_WAIT;
      ST_DN_WAIT:  state_d = div_done ? ST_MUL_RAMP : ST_DN_WAIT;
      ST_MUL_RAMP: state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_SUM;
      ST_SUM:      state_d = ST_FINISH;
      ST_FINISH:   state_d = load_out ? ST_IDLE : ST_FINISH;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q     <= q_item_i.sample[SAMPLE_W-1];
      mag_q     <= q_item_i.sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - q_item_i.sample)
                                               : q_item_i.sample;
      pos_q     <= q_item_i.pos;
      outside_q <= q_item_i.outside;
    end
    if (state_q == ST_UP_SET) begin
      // fade-out start clamps at frame 0 when the fade is longer than the clip
      start_q <= (cfg_i.clip >= cfg_i.fade_out) ? (cfg_i.clip - cfg_i.fade_out) : '0;
      gm1_q   <= cfg_i.fade_out - POS_W'(1);
      if (up_const) begin
        up_q <= up_val;
      end
    end
    if (state_q == ST_UP_WAIT && div_done) begin
      up_q <= div_quot;
    end
    if (state_q == ST_DN_SET && dn_const) begin
      dn_q <= dn_val;
    end
    if (state_q == ST_DN_WAIT && div_done) begin
      dn_q <= div_quot;
    end
    if (state_q == ST_MUL_RAMP) begin
      ud_q <= UD_W'(up_q) * UD_W'(dn_q);
      mg_q <= MG_W'(mag_q) * MG_W'(cfg_i.gain);
    end
    if (state_q == ST_MUL_LO) begin
      plo_q <= PART_W'(mg_q) * PART_W'(ud_q[RAMP_W-1:0]);
    end
    if (state_q == ST_MUL_HI) begin
      phi_q <= PART_W'(mg_q) * PART_W'(ud_q[UD_W-1:RAMP_W]);
    end
    if (state_q == ST_SUM) begin
      prod_q <= PROD_W'(plo_q) + (PROD_W'(phi_q) << RAMP_W);
    end
    if (load_out) begin
      out_sample_q  <= fin_sample;
      out_sat_q     <= fin_sat;
      out_outside_q <= outside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_sat_o     = out_sat_q;
  assign out_outside_o = out_outside_q;

endmodule

/* rtl/audio_fade_gain_envelope.sv */
// ----------------------------------------------------------------------------
// audio_fade_gain_envelope
// linear gain with linear fade-in and fade-out on interleaved q1.15 audio
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one sample word: tdata = sample, first frame of the buffer;
//   tuser = buffer start, which reloads the frame position and channel 0.
//   m_axis returns one word per input word: tdata = scaled sample, tuser =
//   saturated, outside clip. registers sit on the apb port at 4*i.
//   the front end takes a word into a two-entry queue; the back end works one
//   word at a time and pops the next only once the last has reached the
//   output register. each ramp that needs a division occupies the shared
//   bit-serial divider, so words inside active fades take longest; words
//   outside the clip skip the ramps and the gain products.
//   reset clears frame position, channel, queue and output stage and loads
//   the register defaults (unity gain, no fades, clip of one frame, stereo).
//   a stalled m_axis holds the result in the output register; the back end
//   waits there and the queue then fills, after which s_axis tready drops.
//   the user writes registers only while no word is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_fade_gain_envelope_defines.svh"

module audio_fade_gain_envelope #(
  parameter int unsigned MAX_CHANNELS = afge_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afge_pkg::APB_AW-1:0] paddr,
  input  logic [afge_pkg::APB_DW-1:0] pwdata,
  output logic [afge_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // [15:0] sample_in, [47:16] buffer_first_frame
  input  logic [0:0]                  s_axis_tuser,  // [0] buffer_start
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [15:0] sample_out
  output logic [1:0]                  m_axis_tuser   // [0] saturated, [1] outside_clip
);
  import afge_pkg::*;

  cfg_t          cfg_q;
  logic          wr_en;
  logic [2:0]    reg_sel;

  logic          push, pop;
  queue_item_t   push_item, pop_item;
  queue_status_t q_status;
  logic          out_sat, out_outside;
  logic          outside_word, sat_word, out_is_zero, out_at_rail;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain       <= GAIN_RST;
      cfg_q.fade_in    <= '0;
      cfg_q.fade_out   <= '0;
      cfg_q.clip       <= CLIP_RST;
      cfg_q.chan_count <= CHANS_RST;
    end else if (wr_en) begin
      unique case (reg_idx_e'(reg_sel))
        REG_GAIN:     cfg_q.gain       <= pwdata[GAIN_W-1:0];
        REG_FADE_IN:  cfg_q.fade_in    <= pwdata[POS_W-1:0];
        REG_FADE_OUT: cfg_q.fade_out   <= pwdata[POS_W-1:0];
        REG_CLIP:     cfg_q.clip       <= pwdata[POS_W-1:0];
        REG_CHANS:    cfg_q.chan_count <= pwdata[CHAN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(reg_sel))
      REG_GAIN:     prdata = APB_DW'(cfg_q.gain);
      REG_FADE_IN:  prdata = APB_DW'(cfg_q.fade_in);
      REG_FADE_OUT: prdata = APB_DW'(cfg_q.fade_out);
      REG_CLIP:     prdata = APB_DW'(cfg_q.clip);
      REG_CHANS:    prdata = APB_DW'(cfg_q.chan_count);
      default:      prdata = '0;
    endcase
  end

  afge_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .sample_i      (s_axis_tdata[15:0]),
    .buf_start_i   (s_axis_tuser[0]),
    .first_frame_i (s_axis_tdata[47:16]),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  afge_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  afge_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_status_i    (q_status),
    .q_item_i      (pop_item),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sample_o  (m_axis_tdata),
    .out_sat_o     (out_sat),
    .out_outside_o (out_outside)
  );

  assign m_axis_tuser = {out_outside, out_sat};

  assign outside_word = m_axis_tvalid && out_outside;
  assign sat_word     = m_axis_tvalid && out_sat;
  assign out_is_zero  = (m_axis_tdata == 16'h0000) && !out_sat;
  assign out_at_rail  = (m_axis_tdata == 16'h7fff) || (m_axis_tdata == 16'h8000);

  `AFGE_ASSERT_IMP(a_pop_nonempty, pop, !q_status.empty, "back end popped an empty queue")
  `AFGE_ASSERT_NXT(a_push_fills, push && !pop, !q_status.empty, "pushed word missing from queue")
  `AFGE_ASSERT_IMP(a_outside_zero, outside_word, out_is_zero, "outside-clip word not zeroed")
  `AFGE_ASSERT_IMP(a_sat_rail, sat_word, out_at_rail, "saturated word not at a rail")

endmodule

/* tb/sv/tb_audio_fade_gain_envelope.sv */
// ----------------------------------------------------------------------------
// tb_audio_fade_gain_envelope
// Self-checking bench for the fade and gain envelope block. A short directed
// table covers the reset defaults, full scale, saturation, wrap of the frame
// position and odd channel counts. Random buffers follow under several register
// settings, with idling and stalls on both streams. Every result word is checked,
// literal table rows against fixed values and the rest against an in-bench model
// of the envelope arithmetic, and each mapped register write is read back over apb.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_fade_gain_envelope;

  import afge_pkg::*;

  localparam int unsigned MAX_CH          = MAX_CHANNELS_DEF;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned WORDS_PER_PHASE = 195;
  localparam int unsigned HOLD_CYCLES     = 800;
  localparam int unsigned DRAIN_PAD       = 100;
  localparam int unsigned CYCLE_LIMIT     = 1500000;
  localparam logic [2:0]  REG_UNUSED      = 3'd5;

  typedef struct packed {
    logic [15:0] smp;
    logic        sat;
    logic        outside;
  } envelope_out_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [2:0]    reg_idx;
    logic [31:0]   reg_val;
    logic [15:0]   smp;
    logic          start;
    logic [31:0]   first_frame;
    logic          literal;
    envelope_out_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              apb_sel    = 1'b0;
  logic              apb_enable = 1'b0;
  logic              apb_write  = 1'b0;
  logic [APB_AW-1:0] apb_addr   = '0;
  logic [APB_DW-1:0] apb_wdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic        s_valid = 1'b0;
  logic [47:0] s_data  = '0;
  logic [0:0]  s_user  = '0;
  logic        s_axis_tready;
  logic        s_literal = 1'b0;
  envelope_out_t s_want  = '0;

  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // shadow of the registers and the frame tracking state
  cfg_t        shadow;
  logic [31:0] frame_pos = '0;
  int unsigned chan_idx  = 0;

  envelope_out_t pending_out[$];
  stim_row_t     directed_rows[$];

  int unsigned errors       = 0;
  int unsigned words_in     = 0;
  int unsigned words_out    = 0;
  int unsigned sat_seen     = 0;
  int unsigned outside_seen = 0;
  int unsigned settings     = 0;
  int unsigned cycles       = 0;
  int unsigned send_pct     = 0;
  int unsigned recv_pct     = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;

  audio_fade_gain_envelope #(
    .MAX_CHANNELS (MAX_CH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (apb_sel),
    .penable       (apb_enable),
    .pwrite        (apb_write),
    .paddr         (apb_addr),
    .pwdata        (apb_wdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),   // [15:0] sample_in, [47:16] buffer_first_frame
    .s_axis_tuser  (s_user),   // [0] buffer_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // [15:0] sample_out
    .m_axis_tuser  (m_axis_tuser)   // [0] saturated, [1] outside_clip
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- envelope

  function automatic logic [63:0] ramp_up(logic [31:0] p, logic [31:0] len);
    if (len == 32'd0 || p >= len) return 64'd65536;
    if (len == 32'd1) return 64'd0;
    return {16'd0, p, 16'd0} / {32'd0, len - 32'd1};
  endfunction

  function automatic logic [63:0] ramp_down(logic [31:0] p, logic [31:0] total,
                                            logic [31:0] len);
    logic [31:0] st;
    logic [63:0] into;
    logic [63:0] span;
    if (len == 32'd0) return 64'd65536;
    st = (total >= len) ? total - len : 32'd0;
    if (p < st) return 64'd65536;
    if (len == 32'd1) return 64'd0;
    into = {32'd0, p - st};
    span = {32'd0, len - 32'd1};
    if (into > span) return 64'd0;
    return ((span - into) << 16) / span;
  endfunction

  // scales one word and advances frame and channel
  function automatic envelope_out_t fade_gain_word(logic [15:0] smp, logic start,
                                                   logic [31:0] first_frame);
    envelope_out_t r;
    logic          neg;
    logic [63:0]   mag;
    logic [63:0]   prod;
    logic [63:0]   rmag;
    int unsigned   chans;
    r = '0;
    if (start) begin
      frame_pos = first_frame;
      chan_idx  = 0;
    end
    neg = smp[15];
    mag = neg ? (64'h10000 - {48'd0, smp}) : {48'd0, smp};
    if (frame_pos >= shadow.clip) begin
      r.outside = 1'b1;
    end else begin
      prod = mag * {48'd0, shadow.gain};
      prod = prod * ramp_up(frame_pos, shadow.fade_in);
      prod = prod * ramp_down(frame_pos, shadow.clip, shadow.fade_out);
      rmag = (prod + ROUND_ADD) >> RES_SHIFT;
      if (neg) begin
        if (rmag > 64'd32768) begin
          rmag  = 64'd32768;
          r.sat = 1'b1;
        end
        r.smp = 16'(64'h10000 - rmag);
      end else begin
        if (rmag > 64'd32767) begin
          rmag  = 64'd32767;
          r.sat = 1'b1;
        end
        r.smp = rmag[15:0];
      end
    end
    chans = shadow.chan_count;
    if (chans == 0) chans = 1;
    if (chans > MAX_CH) chans = MAX_CH;
    chan_idx++;
    if (chan_idx >= chans) begin
      chan_idx  = 0;
      frame_pos = frame_pos + 32'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk_i) begin
    envelope_out_t w;
    if (rst_ni && s_valid && s_axis_tready) begin
      w = fade_gain_word(s_data[15:0], s_user[0], s_data[47:16]);
      pending_out.push_back(s_literal ? s_want : w);
      words_in++;
    end
  end

  always @(posedge clk_i) begin
    envelope_out_t w;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      words_out++;
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", m_axis_tdata));
      end else begin
        w = pending_out.pop_front();
        if (m_axis_tdata !== w.smp)
          report_mismatch($sformatf("word %0d sample_out %h, wanted %h",
                                    words_out, m_axis_tdata, w.smp));
        if (m_axis_tuser[0] !== w.sat)
          report_mismatch($sformatf("word %0d saturated %b, wanted %b",
                                    words_out, m_axis_tuser[0], w.sat));
        if (m_axis_tuser[1] !== w.outside)
          report_mismatch($sformatf("word %0d outside_clip %b, wanted %b",
                                    words_out, m_axis_tuser[1], w.outside));
        if (m_axis_tuser[0] === 1'b1) sat_seen++;
        if (m_axis_tuser[1] === 1'b1) outside_seen++;
      end
    end
  end

  // receiver: random back-pressure, plus a long hold when asked for
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, pending_out.size());
    $display("tb_audio_fade_gain_envelope failed");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_GAIN:     return {16'd0, shadow.gain};
      REG_FADE_IN:  return shadow.fade_in;
      REG_FADE_OUT: return shadow.fade_out;
      REG_CLIP:     return shadow.clip;
      REG_CHANS:    return {25'd0, shadow.chan_count};
      default:      return 32'd0;
    endcase
  endfunction

  // apb write, then read back where the register exists
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    logic [31:0] got;
    apb_addr   <= {idx, 2'b00};
    apb_wdata  <= value;
    apb_write  <= 1'b1;
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_GAIN:     shadow.gain       = value[15:0];
      REG_FADE_IN:  shadow.fade_in    = value;
      REG_FADE_OUT: shadow.fade_out   = value;
      REG_CLIP:     shadow.clip       = value;
      REG_CHANS:    shadow.chan_count = value[6:0];
      default:      ;
    endcase
    if (idx <= REG_CHANS) begin
      apb_write  <= 1'b0;
      apb_enable <= 1'b0;
      @(posedge clk_i);
      apb_enable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      got = prdata;
      if (got !== reg_value(idx))
        report_mismatch($sformatf("register %0d reads %h, wanted %h",
                                  idx, got, reg_value(idx)));
    end
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(logic [15:0] smp, logic start, logic [31:0] first_frame,
                           logic literal, envelope_out_t want);
    while ($urandom_range(99) < send_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid   <= 1'b1;
    s_data    <= {first_frame, smp};
    s_user    <= start;
    s_literal <= literal;
    s_want    <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and let every pending word come back
  task automatic drain_words();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending_out.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom());
    endcase
  endfunction

  // frame to start a buffer at: near zero, the wrap or a ramp or clip boundary, or random
  function automatic logic [31:0] pick_frame();
    logic [31:0] base;
    case ($urandom_range(7))
      0:       base = 32'd0;
      1:       base = shadow.fade_in;
      2:       base = shadow.clip - shadow.fade_out;
      3:       base = shadow.clip;
      4:       base = 32'hFFFF_FFFF;
      5:       return $urandom();
      default: return $urandom_range(0, 48);
    endcase
    return base + $urandom_range(0, 6) - 32'd3;
  endfunction

  task automatic setup_phase(int unsigned p);
    logic [15:0] gain;
    logic [31:0] fin;
    logic [31:0] fout;
    logic [31:0] clip;
    logic [6:0]  chans;
    gain = 16'($urandom());
    case (p % 4)
      0: begin
        clip  = $urandom_range(0, 40);
        fin   = $urandom_range(0, 44);
        fout  = $urandom_range(0, 48);
        chans = 7'($urandom_range(0, 4));
      end
      1: begin
        gain  = (p == 5) ? 16'h0000 : 16'hFFFF;
        fin   = 32'd1;
        fout  = 32'd1;
        clip  = $urandom_range(2, 30);
        chans = 7'd0;
      end
      2: begin
        fin   = 32'hFFFF_FFFF;
        fout  = 32'hFFFF_FFFF;
        clip  = 32'hFFFF_FFFF;
        chans = 7'h7F;
      end
      default: begin
        fin   = $urandom();
        fout  = $urandom();
        clip  = $urandom();
        chans = 7'd64;
      end
    endcase
    // upper bits carry junk so the masking is exercised
    reg_write(REG_GAIN, {16'($urandom()), gain});
    reg_write(REG_FADE_IN, fin);
    reg_write(REG_FADE_OUT, fout);
    reg_write(REG_CLIP, clip);
    reg_write(REG_CHANS, {25'($urandom()), chans});
    settings++;
  endtask

  function automatic stim_row_t word_row(logic [15:0] smp, logic start,
                                         logic [31:0] first_frame);
    stim_row_t r;
    r = '{kind: ROW_WORD, reg_idx: 3'd0, reg_val: 32'd0, smp: smp, start: start,
          first_frame: first_frame, literal: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [15:0] smp, logic start,
                                            logic [31:0] first_frame,
                                            logic [15:0] out_smp, logic sat,
                                            logic outside);
    stim_row_t r;
    r = word_row(smp, start, first_frame);
    r.literal = 1'b1;
    r.want    = '{smp: out_smp, sat: sat, outside: outside};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, logic [31:0] value);
    stim_row_t r;
    r = word_row(16'd0, 1'b0, 32'd0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = value;
    return r;
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned sent;
    int unsigned run;
    bit          paused;
    shadow = '{gain: GAIN_RST, fade_in: '0, fade_out: '0, clip: CLIP_RST,
               chan_count: CHANS_RST};

    // defaults: unity gain, no fades, clip of one frame, two channels
    directed_rows.push_back(checked_row(16'h7FFF, 1'b1, 32'd0, 16'h7FFF, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h8000, 1'b0, 32'hFFFF_FFFF, 16'h8000, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h1234, 1'b0, 32'd0, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(checked_row(16'hFFFF, 1'b0, 32'd0, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(checked_row(16'h0001, 1'b1, 32'd0, 16'h0001, 1'b0, 1'b0));
    // last frame before the position wraps back to zero
    directed_rows.push_back(checked_row(16'h5555, 1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(checked_row(16'hAAAA, 1'b0, 32'd0, 16'h0000, 1'b0, 1'b1));
    directed_rows.push_back(checked_row(16'h4000, 1'b0, 32'd0, 16'h4000, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h0000, 1'b0, 32'd0, 16'h0000, 1'b0, 1'b0));
    // full gain clamps at both ends of the range
    directed_rows.push_back(reg_row(REG_GAIN, 32'h0000_FFFF));
    directed_rows.push_back(reg_row(REG_CLIP, 32'hFFFF_FFFF));
    directed_rows.push_back(checked_row(16'h7FFF, 1'b1, 32'd0, 16'h7FFF, 1'b1, 1'b0));
    directed_rows.push_back(checked_row(16'h8000, 1'b0, 32'd0, 16'h8000, 1'b1, 1'b0));
    directed_rows.push_back(checked_row(16'hFFFF, 1'b1, 32'd5, 16'hFFF0, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h0001, 1'b0, 32'd0, 16'h0010, 1'b0, 1'b0));
    // overlapping fades, fade-out longer than the clip, zero channel count
    directed_rows.push_back(reg_row(REG_GAIN, 32'hABCD_1000));
    directed_rows.push_back(reg_row(REG_FADE_IN, 32'd4));
    directed_rows.push_back(reg_row(REG_FADE_OUT, 32'd8));
    directed_rows.push_back(reg_row(REG_CLIP, 32'd6));
    directed_rows.push_back(reg_row(REG_CHANS, 32'd0));
    directed_rows.push_back(word_row(16'h7FFF, 1'b1, 32'd0));
    directed_rows.push_back(word_row(16'h8000, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'h4000, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'hC000, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'h7FFF, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'h8001, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'h7FFF, 1'b0, 32'd0));
    // channel count above the maximum, a write to a hole in the map
    directed_rows.push_back(reg_row(REG_CHANS, 32'h0000_007F));
    directed_rows.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
    directed_rows.push_back(word_row(16'h1111, 1'b1, 32'd2));
    directed_rows.push_back(word_row(16'h2222, 1'b0, 32'd0));
    // channel count lowered part way through a frame
    directed_rows.push_back(reg_row(REG_CHANS, 32'd1));
    directed_rows.push_back(word_row(16'h3333, 1'b0, 32'd0));
    directed_rows.push_back(word_row(16'h4444, 1'b0, 32'd0));

    send_pct = 36;
    recv_pct <= 83;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_words();
        reg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_word(directed_rows[i].smp, directed_rows[i].start,
                  directed_rows[i].first_frame, directed_rows[i].literal,
                  directed_rows[i].want);
      end
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      drain_words();
      setup_phase(p);
      if (p < 2) begin
        send_pct = 36;
        recv_pct <= 83;
      end else if (p < 4) begin
        send_pct = 83;
        recv_pct <= 36;
      end else begin
        send_pct = 0;
        recv_pct <= 0;
      end
      // long receiver hold while words keep coming, so the input stalls
      if (p == 4) hold_req <= hold_req + 1;
      sent   = 0;
      paused = 1'b0;
      while (sent < WORDS_PER_PHASE) begin
        if (!paused && sent >= WORDS_PER_PHASE / 2 && (p % 3) == 1) begin
          drain_words();
          paused = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          // noise: a lone word with random flags and frame
          send_word(pick_sample(), 1'($urandom()), $urandom(), 1'b0, '0);
          sent++;
        end else begin
          send_word(pick_sample(), 1'b1, pick_frame(), 1'b0, '0);
          sent++;
          run = $urandom_range(1, 48);
          repeat (run) begin
            send_word(pick_sample(), 1'b0, $urandom(), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain_words();
    if (pending_out.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_out.size()));
    $display("covered %0d words in and %0d out over %0d register settings",
             words_in, words_out, settings + 1);
    $display("%0d results clamped, %0d outside the clip, %0d mismatches",
             sat_seen, outside_seen, errors);
    if (errors == 0) begin
      $display("tb_audio_fade_gain_envelope passed");
    end else begin
      $display("tb_audio_fade_gain_envelope failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/afge_pkg.sv
rtl/afge_front.sv
rtl/afge_queue.sv
rtl/afge_div.sv
rtl/afge_back.sv
rtl/audio_fade_gain_envelope.sv
tb/sv/tb_audio_fade_gain_envelope.sv
